// ----- rtl/core/fat_cluster_chain_mapper_macros.svh -----
// Assertion macros for the FAT cluster chain mapper.
// Included by fat_cluster_chain_mapper.sv, which checks its own logic; no other dependencies.
`ifndef FAT_CLUSTER_CHAIN_MAPPER_MACROS_SVH
`define FAT_CLUSTER_CHAIN_MAPPER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define FCCM_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("fccm assertion failed");
// next-cycle implication
`define FCCM_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("fccm assertion failed");
`else
`define FCCM_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define FCCM_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif

`endif

// ----- rtl/core/fccm_pkg.sv -----
// Shared types and constants of the FAT cluster chain mapper.
// No dependencies; imported by every module of the block.
package fccm_pkg;

	typedef enum logic [1:0] {
		MODE_INIT   = 2'd0,
		MODE_LOCATE = 2'd1,
		MODE_DECODE = 2'd2,
		MODE_MAP    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BAD_LAYOUT = 2'd1,
		ST_NO_INIT    = 2'd2,
		ST_ZERO_SPC   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_F12  = 2'd1,
		KIND_F16  = 2'd2
	} kind_t;

	// configuration register indexes
	localparam logic [2:0] CFG_RSVD   = 3'd0;
	localparam logic [2:0] CFG_COPIES = 3'd1;
	localparam logic [2:0] CFG_SPF    = 3'd2;
	localparam logic [2:0] CFG_RENT   = 3'd3;
	localparam logic [2:0] CFG_TSEC   = 3'd4;
	localparam logic [2:0] CFG_SPC    = 3'd5;

	localparam logic [15:0] F12_LIMIT = 16'd4085;
	localparam logic [15:0] F12_END   = 16'h0FF8;
	localparam logic [15:0] F16_END   = 16'hFFF8;
	localparam logic [15:0] F12_BAD   = 16'h0FF7;
	localparam logic [15:0] F16_BAD   = 16'hFFF7;
	localparam logic [15:0] F12_MASK  = 16'h0FFF;
	// directory entries are 32 bytes
	localparam int unsigned DIR_ENTRY_SHIFT = 5;
	localparam int unsigned DIV_STEPS = 16;

	typedef struct packed {
		logic        start;
		logic [15:0] dividend;
		logic [15:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic [15:0] quot;
	} div_rsp_t;

	typedef struct packed {
		logic [15:0] next;
		logic        chain_end;
		logic        bad;
	} dec_rsp_t;

endpackage

// ----- rtl/core/fccm_div.sv -----
// 16-bit restoring divider, one quotient bit per cycle.
// Depends on fccm_pkg for the request and response structs.
module fccm_div import fccm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam logic [4:0] STEPS = 5'(DIV_STEPS);

	logic [4:0]  cnt_q;
	logic [15:0] rem_q;
	logic [15:0] quo_q;
	logic [15:0] dvs_q;
	logic [16:0] trial;

	// dividend bits shift out of quo_q's top while quotient bits shift in below
	assign trial = {rem_q, quo_q[15]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= STEPS;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (cnt_q != '0) begin
			if (!trial[16]) begin
				rem_q <= trial[15:0];
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= {rem_q[14:0], quo_q[15]};
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
	end

	// a zero divisor yields an all-ones quotient
	assign rsp.busy = (cnt_q != '0);
	assign rsp.quot = quo_q;

endmodule

// ----- rtl/core/fccm_decode.sv -----
// FAT entry decoder: picks the 12- or 16-bit entry out of the read word.
// Depends on fccm_pkg for constants and the result struct.
module fccm_decode import fccm_pkg::*; (
	input  logic        f12,
	input  logic        odd,
	input  logic [15:0] word,
	output dec_rsp_t    rsp
);

	logic [15:0] next;

	always_comb begin
		if (f12) begin
			next = odd ? {4'b0, word[15:4]} : (word & F12_MASK);
		end else begin
			next = word;
		end
	end

	assign rsp.next      = next;
	assign rsp.chain_end = f12 ? (next >= F12_END) : (next >= F16_END);
	assign rsp.bad       = f12 ? (next == F12_BAD) : (next == F16_BAD);

endmodule

// ----- rtl/core/fat_cluster_chain_mapper.sv -----
// FAT12/16 cluster chain mapper: volume layout, FAT entry lookup and cluster mapping.
// Depends on fccm_pkg, fccm_div, fccm_decode and the assertion macro header.
//
// Usage: geometry registers are written on the cfg channel (index, data) while
// the block is idle; cfg_ready is always high. Requests arrive on s_*: mode in
// s_tuser, cluster and FAT word in s_tdata. One result per request leaves on m_*:
// status in m_tuser, the other fields in m_tdata.
// An init request must run first; until then other requests answer "not
// initialised". One request is worked at a time and s_tready is low meanwhile.
// An accepted request passes S_START; an init that is taken goes on through S_LAYOUT
// and S_DIV, while locate, decode, map and refused or early answers go straight to
// S_FIN, which loads the output register. The 16-step divider that derives the
// cluster count is what makes an init longer; divisions by the sector size (a
// power of two) are shifts. A new item is taken only once the last has left S_FIN.
// The output register holds a result until m_tready takes it; the next request
// may be accepted meanwhile and waits in its last step if the register is full.
// Reset restores the default geometry, clears the layout and empties the output.
`include "fat_cluster_chain_mapper_macros.svh"

module fat_cluster_chain_mapper import fccm_pkg::*; #(
	parameter int unsigned SECTOR_BYTES = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // cluster[15:0], fat_word[31:16]
	input  logic [1:0]  s_tuser,   // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // fat_kind[1:0], sector_addr[17:2], byte_offset[26:18],
	                               // sector_count[42:27], next_cluster[58:43],
	                               // chain_end[59], cluster_bad[60], zeros above
	output logic [1:0]  m_tuser,   // status[1:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam logic [15:0] SB_M1    = 16'(SECTOR_BYTES - 1);
	localparam int unsigned SB_SHIFT = $clog2(SECTOR_BYTES);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_START  = 5'b00010,
		S_LAYOUT = 5'b00100,
		S_DIV    = 5'b01000,
		S_FIN    = 5'b10000
	} state_t;

	state_t state_q;

	logic [15:0] rsvd_q, spf_q, rent_q, tsec_q;
	logic [7:0]  copies_q, spc_q;

	kind_t       kind_q;
	logic [15:0] rds_q, root_start_q, data_start_q, ct_q;

	mode_t       mode_q;
	logic [15:0] cl_q, word_q;
	logic [15:0] prod_q, rds_new_q, ds_new_q;

	logic        m_tvalid_q;
	logic [63:0] m_tdata_q;
	logic [1:0]  m_tuser_q;

	div_req_t div_req;
	div_rsp_t div_rsp;
	dec_rsp_t dec_rsp;

	logic        accept, refused, fin_go;
	logic [15:0] rds_num, rds_calc, off, off_mod, ds_sum, dsec;
	logic [15:0] mul_a;
	logic [7:0]  mul_b;
	logic [23:0] mul_full;
	kind_t       new_kind;

	status_t     r_status;
	kind_t       r_kind;
	logic [15:0] r_addr, r_count, r_next;
	logic [8:0]  r_boff;
	logic        r_end, r_bad;

	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign refused   = (spf_q == '0) || (tsec_q == '0);
	assign fin_go    = (state_q == S_FIN) && (!m_tvalid_q || m_tready);

	assign rds_num  = {rent_q[15-DIR_ENTRY_SHIFT:0], {DIR_ENTRY_SHIFT{1'b0}}} + SB_M1;
	assign rds_calc = rds_num >> SB_SHIFT;
	assign off      = (kind_q == KIND_F12) ? (cl_q + {1'b0, cl_q[15:1]}) : {cl_q[14:0], 1'b0};
	assign off_mod  = off & SB_M1;

	// one multiplier: FAT area size at init, cluster offset at map
	assign mul_a    = (mode_q == MODE_INIT) ? spf_q : (cl_q - 16'd2);
	assign mul_b    = (mode_q == MODE_INIT) ? copies_q : spc_q;
	assign mul_full = {8'b0, mul_a} * {16'b0, mul_b};

	assign ds_sum = rsvd_q + prod_q + rds_new_q;
	assign dsec   = tsec_q - ds_sum;
	assign new_kind = (div_rsp.quot < F12_LIMIT) ? KIND_F12 : KIND_F16;

	// the divider only works out the cluster count at init
	assign div_req.start    = (state_q == S_LAYOUT);
	assign div_req.dividend = dsec;
	assign div_req.divisor  = {8'b0, spc_q};

	fccm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	fccm_decode u_decode (
		.f12  (kind_q == KIND_F12),
		.odd  (cl_q[0]),
		.word (word_q),
		.rsp  (dec_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsvd_q   <= 16'd1;
			copies_q <= 8'd2;
			spf_q    <= 16'd9;
			rent_q   <= 16'd224;
			tsec_q   <= 16'd2880;
			spc_q    <= 8'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_RSVD:   rsvd_q   <= cfg_data;
				CFG_COPIES: copies_q <= cfg_data[7:0];
				CFG_SPF:    spf_q    <= cfg_data;
				CFG_RENT:   rent_q   <= cfg_data;
				CFG_TSEC:   tsec_q   <= cfg_data;
				CFG_SPC:    spc_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_START;
				end
				S_START: begin
					if (mode_q == MODE_INIT && !refused) begin
						state_q <= S_LAYOUT;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_LAYOUT: state_q <= S_DIV;
				S_DIV: begin
					if (!div_rsp.busy) state_q <= S_FIN;
				end
				S_FIN: begin
					if (fin_go) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item and intermediate values
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode_t'(s_tuser);
			cl_q   <= s_tdata[15:0];
			word_q <= s_tdata[31:16];
		end
		if (state_q == S_START) begin
			prod_q    <= mul_full[15:0];
			rds_new_q <= rds_calc;
		end
		if (state_q == S_LAYOUT) ds_new_q <= ds_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q       <= KIND_NONE;
			rds_q        <= '0;
			root_start_q <= '0;
			data_start_q <= '0;
			ct_q         <= '0;
		end else if (fin_go && mode_q == MODE_INIT && !refused) begin
			kind_q       <= new_kind;
			rds_q        <= rds_new_q;
			root_start_q <= ds_new_q - rds_new_q;
			data_start_q <= ds_new_q;
			ct_q         <= div_rsp.quot;
		end
	end

	always_comb begin
		r_status = ST_OK;
		r_kind   = kind_q;
		r_addr   = '0;
		r_boff   = '0;
		r_count  = '0;
		r_next   = '0;
		r_end    = 1'b0;
		r_bad    = 1'b0;
		if (mode_q == MODE_INIT) begin
			if (refused) begin
				r_status = ST_BAD_LAYOUT;
			end else begin
				r_status = (spc_q == '0) ? ST_ZERO_SPC : ST_OK;
				r_kind   = new_kind;
				r_addr   = ds_new_q;
				r_count  = rds_new_q;
			end
		end else if (kind_q == KIND_NONE) begin
			r_status = ST_NO_INIT;
			r_end    = (mode_q == MODE_DECODE);
		end else begin
			unique case (mode_q)
				MODE_LOCATE: begin
					r_addr = rsvd_q + (off >> SB_SHIFT);
					r_boff = off_mod[8:0];
				end
				MODE_DECODE: begin
					r_next = dec_rsp.next;
					r_end  = dec_rsp.chain_end;
					r_bad  = dec_rsp.bad;
				end
				MODE_MAP: begin
					if (cl_q == '0) begin
						r_addr  = root_start_q;
						r_count = rds_q;
					end else begin
						r_addr  = prod_q + data_start_q;
						r_count = {8'b0, spc_q};
						if (spc_q == '0) r_status = ST_ZERO_SPC;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (fin_go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			m_tuser_q <= r_status;
			m_tdata_q <= {3'b0, r_bad, r_end, r_next, r_count, r_boff, r_addr, r_kind};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`FCCM_ASSERT_IMP(a_div_only_waiting, clk, arst_n, div_rsp.busy, state_q == S_DIV)
	`FCCM_ASSERT_NXT(a_accept_starts, clk, arst_n, accept, state_q == S_START)
	`FCCM_ASSERT_IMP(a_kind_from_count, clk, arst_n, kind_q != KIND_NONE,
		(kind_q == KIND_F12) == (ct_q < F12_LIMIT))

endmodule

// ----- sim/fat_chain_checker.sv -----
// Checker for the FAT cluster chain mapper: tracks geometry writes, predicts each answer.
// Watches the request, answer and register channels; compares answers in order.
// Depends on fccm_pkg only.
module fat_chain_checker import fccm_pkg::*; #(
	parameter int unsigned SECTOR_BYTES = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,
	input  logic [1:0]  m_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          errors,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		status_t     status;
		kind_t       kind;
		logic [15:0] sector_addr;
		logic [8:0]  byte_offset;
		logic [15:0] sector_count;
		logic [15:0] next_cluster;
		logic        chain_end;
		logic        cluster_bad;
	} answer_t;

	// geometry registers
	logic [15:0] rsvd_secs, secs_per_fat, dir_entries, vol_secs;
	logic [7:0]  fat_count, secs_per_clus;
	// derived layout
	kind_t       kind_now;
	logic [15:0] dir_secs, dir_start, data_first;

	answer_t expected_answers[$];

	function automatic answer_t resolve_request(input mode_t mode, input logic [15:0] cl,
	                                            input logic [15:0] word);
		answer_t     a;
		logic [15:0] rds, fats, ds, dsec, ct, off;
		a.status       = ST_OK;
		a.kind         = KIND_NONE;
		a.sector_addr  = '0;
		a.byte_offset  = '0;
		a.sector_count = '0;
		a.next_cluster = '0;
		a.chain_end    = 1'b0;
		a.cluster_bad  = 1'b0;
		if (mode == MODE_INIT) begin
			if (secs_per_fat == 16'd0 || vol_secs == 16'd0) begin
				// refused: layout stays as it was
				a.status = ST_BAD_LAYOUT;
			end else begin
				rds  = dir_entries << DIR_ENTRY_SHIFT;
				rds  = rds + 16'(SECTOR_BYTES - 1);
				rds  = rds / 16'(SECTOR_BYTES);
				fats = fat_count * secs_per_fat;
				ds   = rsvd_secs + fats + rds;
				dsec = vol_secs - ds;
				if (secs_per_clus == 8'd0) begin
					ct       = 16'hFFFF;
					a.status = ST_ZERO_SPC;
				end else begin
					ct = dsec / {8'd0, secs_per_clus};
				end
				dir_secs       = rds;
				data_first     = ds;
				dir_start      = ds - rds;
				kind_now       = (ct < F12_LIMIT) ? KIND_F12 : KIND_F16;
				a.sector_addr  = ds;
				a.sector_count = rds;
			end
		end else if (kind_now == KIND_NONE) begin
			a.status    = ST_NO_INIT;
			a.chain_end = (mode == MODE_DECODE);
		end else begin
			case (mode)
				MODE_LOCATE: begin
					off = (kind_now == KIND_F12) ? cl + (cl >> 1) : cl << 1;
					a.sector_addr = rsvd_secs + off / 16'(SECTOR_BYTES);
					a.byte_offset = 9'(off % 16'(SECTOR_BYTES));
				end
				MODE_DECODE: begin
					if (kind_now == KIND_F12) begin
						// odd clusters sit in the high three nibbles
						a.next_cluster = cl[0] ? (word >> 4) : (word & F12_MASK);
						a.chain_end    = a.next_cluster >= F12_END;
						a.cluster_bad  = a.next_cluster == F12_BAD;
					end else begin
						a.next_cluster = word;
						a.chain_end    = word >= F16_END;
						a.cluster_bad  = word == F16_BAD;
					end
				end
				default: begin
					if (cl == 16'd0) begin
						a.sector_addr  = dir_start;
						a.sector_count = dir_secs;
					end else begin
						a.sector_addr  = (cl - 16'd2) * {8'd0, secs_per_clus} + data_first;
						a.sector_count = {8'd0, secs_per_clus};
						if (secs_per_clus == 8'd0)
							a.status = ST_ZERO_SPC;
					end
				end
			endcase
		end
		a.kind = kind_now;
		return a;
	endfunction

	task automatic check_field(input string name, input logic [15:0] exp_v,
	                           input logic [15:0] act_v);
		if (act_v !== exp_v) begin
			errors++;
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			rsvd_secs     = 16'd1;
			fat_count     = 8'd2;
			secs_per_fat  = 16'd9;
			dir_entries   = 16'd224;
			vol_secs      = 16'd2880;
			secs_per_clus = 8'd1;
			kind_now      = KIND_NONE;
			dir_secs      = '0;
			dir_start     = '0;
			data_first    = '0;
			expected_answers.delete();
			errors        = 0;
			outstanding   = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_RSVD:   rsvd_secs     = cfg_data;
					CFG_COPIES: fat_count     = cfg_data[7:0];
					CFG_SPF:    secs_per_fat  = cfg_data;
					CFG_RENT:   dir_entries   = cfg_data;
					CFG_TSEC:   vol_secs      = cfg_data;
					CFG_SPC:    secs_per_clus = cfg_data[7:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				expected_answers.push_back(resolve_request(mode_t'(s_tuser), s_tdata[15:0],
				                                           s_tdata[31:16]));
			if (m_tvalid && m_tready) begin
				if (expected_answers.size() == 0) begin
					errors++;
					$error("answer item with no request waiting");
				end else begin
					want = expected_answers.pop_front();
					check_field("status", 16'(want.status), 16'(m_tuser));
					check_field("fat_kind", 16'(want.kind), 16'(m_tdata[1:0]));
					check_field("sector_addr", want.sector_addr, m_tdata[17:2]);
					check_field("byte_offset", 16'(want.byte_offset), 16'(m_tdata[26:18]));
					check_field("sector_count", want.sector_count, m_tdata[42:27]);
					check_field("next_cluster", want.next_cluster, m_tdata[58:43]);
					check_field("chain_end", 16'(want.chain_end), 16'(m_tdata[59]));
					check_field("cluster_bad", 16'(want.cluster_bad), 16'(m_tdata[60]));
					check_field("tdata padding", 16'd0, 16'(m_tdata[63:61]));
				end
			end
			outstanding = expected_answers.size();
		end
	end

endmodule

// ----- sim/testbench.sv -----
// Top of the FAT cluster chain mapper testbench: clock, reset, stimulus and verdict.
// Instantiates fat_cluster_chain_mapper and fat_chain_checker; uses fccm_pkg.
module testbench;
	import fccm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SECTOR_BYTES = 512;
	localparam int          CYCLE_LIMIT  = 1000000;
	localparam int          PHASES       = 18;
	localparam int          PHASE_ITEMS  = 63;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid, s_tready;
	logic [31:0] s_tdata;   // cluster[15:0], fat_word[31:16]
	logic [1:0]  s_tuser;   // mode[1:0]
	logic        m_tvalid, m_tready;
	logic [63:0] m_tdata;   // fat_kind[1:0], sector_addr[17:2], byte_offset[26:18],
	                        // sector_count[42:27], next_cluster[58:43],
	                        // chain_end[59], cluster_bad[60]
	logic [1:0]  m_tuser;   // status[1:0]
	logic        cfg_valid, cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	int errors, outstanding;
	int cycles     = 0;
	int idle_pct   = 0;
	int stall_pct  = 0;

	fat_cluster_chain_mapper #(.SECTOR_BYTES(SECTOR_BYTES)) DUT (.*);

	fat_chain_checker #(.SECTOR_BYTES(SECTOR_BYTES)) checker_i (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send_request(input mode_t mode, input logic [15:0] cl,
	                            input logic [15:0] word);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {word, cl};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic load_geometry(input logic [15:0] rsvd, input logic [7:0] copies,
	                             input logic [15:0] spf, input logic [15:0] rent,
	                             input logic [15:0] tsec, input logic [7:0] spc);
		wait_idle();
		write_reg(CFG_RSVD, rsvd);
		write_reg(CFG_COPIES, {8'd0, copies});
		write_reg(CFG_SPF, spf);
		write_reg(CFG_RENT, rent);
		write_reg(CFG_TSEC, tsec);
		write_reg(CFG_SPC, {8'd0, spc});
		cfg_valid <= 1'b0;
	endtask

	task automatic pick_geometry();
		logic [15:0] rent;
		case ($urandom_range(3))
			0: begin
				case ($urandom_range(2))
					0: rent = 16'd112;
					1: rent = 16'd224;
					default: rent = 16'd512;
				endcase
				load_geometry(16'($urandom_range(1, 4)), 8'($urandom_range(1, 2)),
				              16'($urandom_range(1, 12)), rent,
				              16'($urandom_range(720, 8000)), 8'd1 << $urandom_range(2));
			end
			1: load_geometry(16'($urandom_range(1, 8)), 8'd2, 16'($urandom_range(32, 256)),
			                 16'd512, 16'($urandom_range(20000, 65535)),
			                 8'd1 << $urandom_range(3));
			2: load_geometry(16'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
			                 16'($urandom), 8'($urandom));
			default: load_geometry($urandom_range(1) ? 16'hFFFF : 16'd0,
			                       $urandom_range(1) ? 8'hFF : 8'd0,
			                       $urandom_range(1) ? 16'hFFFF : 16'd1,
			                       $urandom_range(1) ? 16'hFFFF : 16'd0,
			                       $urandom_range(1) ? 16'hFFFF : 16'd1,
			                       $urandom_range(1) ? 8'hFF : 8'd0);
		endcase
	endtask

	// words biased toward end-of-chain and bad markers for both FAT widths and nibble halves
	function automatic logic [15:0] pick_word();
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return 16'hFFF0 | 16'($urandom_range(15));
			2: return {12'hFF0 | 12'($urandom_range(15)), 4'($urandom_range(15))};
			default: return 16'($urandom_range(15) << 12) | 16'hFF0 | 16'($urandom_range(15));
		endcase
	endfunction

	task automatic random_request();
		mode_t       mode;
		logic [15:0] cl;
		if ($urandom_range(19) == 0)
			mode = MODE_INIT;
		else
			mode = mode_t'($urandom_range(1, 3));
		case ($urandom_range(3))
			0: cl = 16'($urandom);
			1: cl = 16'($urandom_range(3));
			default: cl = 16'($urandom_range(4200));
		endcase
		send_request(mode, cl, pick_word());
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = MODE_INIT;
		cfg_valid = 1'b0;
		cfg_index = CFG_RSVD;
		cfg_data  = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// before any init
		send_request(MODE_LOCATE, 16'd5, 16'd0);
		send_request(MODE_DECODE, 16'd3, 16'hFFFF);
		send_request(MODE_MAP, 16'd0, 16'd0);
		// default geometry is a 1.44 MB floppy, FAT12
		send_request(MODE_INIT, 16'd0, 16'd0);
		send_request(MODE_LOCATE, 16'd0, 16'd0);
		send_request(MODE_LOCATE, 16'd341, 16'd0);
		send_request(MODE_LOCATE, 16'hFFFF, 16'd0);
		send_request(MODE_DECODE, 16'd2, 16'hFFF8);
		send_request(MODE_DECODE, 16'd3, 16'hFF70);
		send_request(MODE_DECODE, 16'd4, 16'h0000);
		send_request(MODE_DECODE, 16'd5, 16'hFFFF);
		send_request(MODE_MAP, 16'd0, 16'd0);
		send_request(MODE_MAP, 16'd1, 16'd0);
		send_request(MODE_MAP, 16'hFFFF, 16'd0);
		// refused inits keep the layout
		load_geometry(16'd1, 8'd2, 16'd0, 16'd224, 16'd2880, 8'd1);
		send_request(MODE_INIT, 16'd0, 16'd0);
		load_geometry(16'd1, 8'd2, 16'd9, 16'd224, 16'd0, 8'd1);
		send_request(MODE_INIT, 16'd0, 16'd0);
		send_request(MODE_MAP, 16'd2, 16'd0);
		// zero sectors per cluster
		load_geometry(16'd1, 8'd2, 16'd9, 16'd224, 16'd2880, 8'd0);
		send_request(MODE_INIT, 16'd0, 16'd0);
		send_request(MODE_MAP, 16'd7, 16'd0);
		send_request(MODE_MAP, 16'd0, 16'd0);
		// FAT16 volume
		load_geometry(16'd4, 8'd2, 16'd64, 16'd512, 16'd65535, 8'd4);
		send_request(MODE_INIT, 16'd0, 16'd0);
		send_request(MODE_DECODE, 16'd9, 16'hFFF7);
		send_request(MODE_DECODE, 16'd9, 16'hFFF8);
		send_request(MODE_LOCATE, 16'd300, 16'd0);
		// everything at its maximum
		load_geometry(16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
		send_request(MODE_INIT, 16'd0, 16'd0);
		send_request(MODE_MAP, 16'hFFFF, 16'd0);
		send_request(MODE_LOCATE, 16'hFFFF, 16'd0);

		for (int ph = 0; ph < PHASES; ph++) begin
			pick_geometry();
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 68; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 68; end
				default: begin idle_pct = 6; stall_pct = 6; end
			endcase
			send_request(MODE_INIT, 16'($urandom), 16'($urandom));
			repeat (PHASE_ITEMS)
				random_request();
		end

		wait_idle();
		// give stray answers time to show
		repeat (80) @(negedge clk);
		if (errors == 0 && outstanding == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- fat_cluster_chain_mapper.f -----
+incdir+rtl/core
rtl/core/fccm_pkg.sv
rtl/core/fccm_div.sv
rtl/core/fccm_decode.sv
rtl/core/fat_cluster_chain_mapper.sv
sim/fat_chain_checker.sv
sim/testbench.sv
